// File: rtl/ttmw_pkg.sv
// Shared types, widths, stage counts and fixed-point constants of the mix-and-window block.
package ttmw_pkg;

	// Frame length used when the top level is not overridden
	localparam int unsigned FRAME_SIZE_DEF = 2048;

	// Field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned COMB_W   = 17;
	localparam int unsigned OUT_W    = 17;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned PH_W     = 32;

	// Pipeline depth per section; stage k is loaded by enable bit k-1
	localparam int unsigned PH_N       = 4;
	localparam int unsigned COS_N      = 16;
	localparam int unsigned WS_N       = 4;
	localparam int unsigned OUT_N      = 2;
	localparam int unsigned COS_BASE   = PH_N;
	localparam int unsigned WS_BASE    = PH_N + COS_N;
	localparam int unsigned OUT_BASE   = PH_N + COS_N + WS_N;
	localparam int unsigned NUM_STAGES = PH_N + COS_N + WS_N + OUT_N;

	// Register codes
	typedef enum logic {
		COMB_MUL = 1'b0,
		COMB_ADD = 1'b1
	} comb_mode_t;

	typedef enum logic [1:0] {
		WIN_NONE    = 2'd0,
		WIN_HAMMING = 2'd1,
		WIN_HANN    = 2'd2,
		WIN_BH      = 2'd3
	} win_kind_t;

	typedef enum logic {
		REG_COMBINE = 1'b0,
		REG_WINDOW  = 1'b1
	} reg_idx_t;

	// Cosine of one harmonic: magnitude in Q30 and sign
	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
	} cos_val_t;

	// Q30 constants
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [29:0] EIGHTH_TURN = 30'h2000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// Window coefficients, Q30
	localparam logic [29:0] C_HAM0 = 30'd579820585;
	localparam logic [29:0] C_HAM1 = 30'd493921239;
	localparam logic [29:0] C_HANN = 30'd536870912;
	localparam logic [29:0] C_BH0  = 30'd385204879;
	localparam logic [29:0] C_BH1  = 30'd524297395;
	localparam logic [29:0] C_BH2  = 30'd151698245;
	localparam logic [29:0] C_BH3  = 30'd12541305;

	// Exact reciprocals for the Horner divisions of a 30-bit value:
	// floor(y / C) = (y * ceil(2^K / C)) >> K with K = 30 + ceil(log2(C))
	localparam logic [31:0] COS_RCP [4] = '{
		32'(((64'd1 << 36) + 64'd55) / 64'd56),
		32'(((64'd1 << 35) + 64'd29) / 64'd30),
		32'(((64'd1 << 34) + 64'd11) / 64'd12),
		32'(((64'd1 << 31) + 64'd1) / 64'd2)
	};
	localparam int unsigned COS_SHIFT [4] = '{36, 35, 34, 31};

	localparam logic [31:0] SIN_RCP [4] = '{
		32'(((64'd1 << 37) + 64'd71) / 64'd72),
		32'(((64'd1 << 36) + 64'd41) / 64'd42),
		32'(((64'd1 << 35) + 64'd19) / 64'd20),
		32'(((64'd1 << 33) + 64'd5) / 64'd6)
	};
	localparam int unsigned SIN_SHIFT [4] = '{37, 36, 35, 33};

endpackage

// File: rtl/ttmw_phase.sv
// Phase generator: position to a 32-bit turn fraction for the first three harmonics.
module ttmw_phase
	import ttmw_pkg::*;
#(
	parameter int unsigned FRAME_SIZE = FRAME_SIZE_DEF
) (
	input  logic                      clk,
	input  logic [PH_N-1:0]           en,
	input  logic [POS_W-1:0]          pos,
	output logic [2:0][PH_W-1:0]      ph
);

	// floor(2^48 / FRAME_SIZE); the estimate below is at most one short
	localparam logic [44:0] RECIP = 45'((64'd1 << 48) / FRAME_SIZE);
	localparam logic [17:0] FS    = 18'(FRAME_SIZE);

	logic [55:0]     est;
	logic [35:0]     qfs_full;
	logic [17:0]     rem;
	logic [PH_W-1:0] q_s1;
	logic [PH_W-1:0] q_s2;
	logic [17:0]     qfs_s2;
	logic [PH_W-1:0] ph_s3;
	logic [2:0][PH_W-1:0] ph_s4;

	// Estimate of pos * 2^32 / FRAME_SIZE, kept modulo 2^32
	assign est = 56'(pos) * 56'(RECIP);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s1 <= est[47:16];
		end
	end

	// Back-multiply; only the low bits matter since the remainder is below 2*FS
	assign qfs_full = {18'd0, q_s1[17:0]} * {18'd0, FS};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_s2   <= q_s1;
			qfs_s2 <= qfs_full[17:0];
		end
	end

	// Correct the estimate by one when the remainder reaches FS
	assign rem = 18'd0 - qfs_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ph_s3 <= q_s2 + PH_W'(rem >= FS);
		end
	end

	// Harmonic one as is, harmonics two and three by shift and add
	always_ff @(posedge clk) begin
		if (en[3]) begin
			ph_s4[0] <= ph_s3;
			ph_s4[1] <= {ph_s3[PH_W-2:0], 1'b0};
			ph_s4[2] <= ph_s3 + {ph_s3[PH_W-2:0], 1'b0};
		end
	end

	assign ph = ph_s4;

endmodule

// File: rtl/ttmw_cos.sv
// Cosine lane: quadrant fold, then a pipelined Horner evaluation of cos or sin in Q30.
module ttmw_cos
	import ttmw_pkg::*;
(
	input  logic             clk,
	input  logic [COS_N-1:0] en,
	input  logic [PH_W-1:0]  ph,
	output cos_val_t         cval
);

	logic [1:0]  quad;
	logic [29:0] r;
	logic        odd;
	logic        use_sin;
	logic [29:0] u;
	logic [60:0] xp;
	logic [59:0] sq;
	logic [60:0] fp;
	logic [30:0] mag_next;

	logic [29:0] u_s1;
	logic [29:0] x_s   [2:15];
	logic [29:0] x2_s  [3:12];
	logic        sin_s [1:15];
	logic        neg_s [1:16];
	logic [30:0] t_s   [4];
	logic [30:0] mag_s16;

	// Fold the turn onto [0, pi/4]; the polynomial is sin near the quarter-turn edges
	always_comb begin
		quad    = ph[31:30];
		r       = ph[29:0];
		odd     = quad[0];
		use_sin = odd ? (r < EIGHTH_TURN) : (r > EIGHTH_TURN);
		if (odd == use_sin) begin
			u = r;
		end else begin
			u = 30'(ONE_Q30 - {1'b0, r});
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u_s1 <= u;
		end
	end

	// Angle in radians, Q30
	assign xp = 61'(u_s1) * 61'(HALF_PI_Q30);

	// Square of the angle
	assign sq = 60'(x_s[2]) * 60'(x_s[2]);

	// Angle, square and side data riding along the lane
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sin_s[1] <= use_sin;
			neg_s[1] <= quad[1] ^ quad[0];
		end
		if (en[1]) begin
			x_s[2] <= xp[59:30];
		end
		if (en[2]) begin
			x2_s[3] <= sq[59:30];
		end
		for (int k = 2; k <= 15; k++) begin
			if (en[k-1]) begin
				sin_s[k] <= sin_s[k-1];
			end
		end
		for (int k = 2; k <= 16; k++) begin
			if (en[k-1]) begin
				neg_s[k] <= neg_s[k-1];
			end
		end
		for (int k = 3; k <= 15; k++) begin
			if (en[k-1]) begin
				x_s[k] <= x_s[k-1];
			end
		end
		for (int k = 4; k <= 12; k++) begin
			if (en[k-1]) begin
				x2_s[k] <= x2_s[k-1];
			end
		end
	end

	// Horner steps: t = 1 - ((x2 * t) >> 30) / C, three stages each
	for (genvar j = 0; j < 4; j++) begin : g_step
		localparam int unsigned KA = 4 + 3 * j;

		logic [29:0] y_next;
		logic [31:0] rcp;
		logic [61:0] d_next;
		logic [29:0] q;
		logic [29:0] y_sa;
		logic [61:0] d_sb;

		if (j == 0) begin : g_first
			// t starts at one, so the product is x2 itself
			assign y_next = x2_s[KA-1];
		end else begin : g_rest
			logic [60:0] yp;
			assign yp     = 61'(x2_s[KA-1]) * 61'(t_s[j-1]);
			assign y_next = yp[59:30];
		end

		always_ff @(posedge clk) begin
			if (en[KA-1]) begin
				y_sa <= y_next;
			end
		end

		// Exact division by a small constant through its reciprocal
		assign rcp    = sin_s[KA] ? SIN_RCP[j] : COS_RCP[j];
		assign d_next = 62'(y_sa) * 62'(rcp);

		always_ff @(posedge clk) begin
			if (en[KA]) begin
				d_sb <= d_next;
			end
		end

		assign q = sin_s[KA+1] ? 30'(d_sb >> SIN_SHIFT[j]) : 30'(d_sb >> COS_SHIFT[j]);

		always_ff @(posedge clk) begin
			if (en[KA+1]) begin
				t_s[j] <= ONE_Q30 - {1'b0, q};
			end
		end
	end

	// sin needs the final multiply by x
	assign fp       = 61'(x_s[15]) * 61'(t_s[3]);
	assign mag_next = sin_s[15] ? fp[60:30] : t_s[3];

	always_ff @(posedge clk) begin
		if (en[15]) begin
			mag_s16 <= mag_next;
		end
	end

	assign cval.neg = neg_s[16];
	assign cval.mag = mag_s16;

endmodule

// File: rtl/ttmw_wsum.sv
// Window weight: coefficient products, signed sum at Q60, clamp and rounding to Q1.15.
module ttmw_wsum
	import ttmw_pkg::*;
(
	input  logic                 clk,
	input  logic [WS_N-1:0]      en,
	input  win_kind_t            kind,
	input  cos_val_t [2:0]       cv,
	output logic [WEIGHT_W-1:0]  weight
);

	localparam logic [61:0] ONE_Q60  = 62'(64'd1 << 60);
	localparam logic [60:0] HALF_LSB = 61'(64'd1 << 44);

	logic [29:0] c0;
	logic [29:0] c1;
	logic [29:0] c2;
	logic [29:0] c3;
	logic [60:0] pm [3];

	logic signed [62:0] base;
	logic signed [62:0] trm [3];
	logic [60:0]        wc;
	logic [60:0]        rs;

	logic [59:0]        p_s1   [3];
	logic               sub_s1 [3];
	logic [29:0]        c0_s1;
	logic               none_s1;
	logic signed [62:0] s01_s2;
	logic signed [62:0] s23_s2;
	logic               none_s2;
	logic signed [62:0] w_s3;
	logic               none_s3;
	logic [WEIGHT_W-1:0] weight_s4;

	// Coefficients for the selected window
	always_comb begin
		c0 = '0;
		c1 = '0;
		c2 = '0;
		c3 = '0;
		case (kind)
			WIN_HAMMING: begin
				c0 = C_HAM0;
				c1 = C_HAM1;
			end
			WIN_HANN: begin
				c0 = C_HANN;
				c1 = C_HANN;
			end
			WIN_BH: begin
				c0 = C_BH0;
				c1 = C_BH1;
				c2 = C_BH2;
				c3 = C_BH3;
			end
			default: begin
				c0 = '0;
			end
		endcase
	end

	assign pm[0] = 61'(cv[0].mag) * 61'(c1);
	assign pm[1] = 61'(cv[1].mag) * 61'(c2);
	assign pm[2] = 61'(cv[2].mag) * 61'(c3);

	// Products; the first and third terms enter with a minus sign
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= pm[i][59:0];
			end
			sub_s1[0] <= ~cv[0].neg;
			sub_s1[1] <= cv[1].neg;
			sub_s1[2] <= ~cv[2].neg;
			c0_s1     <= c0;
			none_s1   <= (kind == WIN_NONE);
		end
	end

	// Partial sums
	always_comb begin
		base = signed'({3'd0, c0_s1, 30'd0});
		for (int i = 0; i < 3; i++) begin
			trm[i] = sub_s1[i] ? -signed'({3'd0, p_s1[i]}) : signed'({3'd0, p_s1[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			s01_s2  <= base + trm[0];
			s23_s2  <= trm[1] + trm[2];
			none_s2 <= none_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			w_s3    <= s01_s2 + s23_s2;
			none_s3 <= none_s2;
		end
	end

	// Clamp to [0, 1] and round half up to Q1.15
	always_comb begin
		if (w_s3[62]) begin
			wc = '0;
		end else if (w_s3[61:0] > ONE_Q60) begin
			wc = ONE_Q60[60:0];
		end else begin
			wc = w_s3[60:0];
		end
		rs = wc + HALF_LSB;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			weight_s4 <= none_s3 ? WEIGHT_W'(16'h8000) : rs[60:45];
		end
	end

	assign weight = weight_s4;

endmodule

// File: rtl/two_tone_mix_and_window.sv
// Top level: sample combine, window weight pipeline, output rounding and register port.
//
//  channel  dir  handshake               contents
//  s_*      in   s_tvalid / s_tready     sample_a, sample_b, sample_position
//  m_*      out  m_tvalid / m_tready     windowed_sample, frame_end (tlast)
//  apb      in   psel, penable, pwrite   combine_mode @0x0, window_kind @0x4
//
// One item per clock sustained while m_tready is high. The cosine lanes are the
// longest section (fold, angle, square, four Horner steps of three stages, final
// multiply). Each stage has a valid bit and takes a new item when it is empty or
// when the stage after it moves, so bubbles close up and a stalled m_tready holds
// the items once no stage is empty. Reset clears the valid bits and both registers.
module two_tone_mix_and_window
	import ttmw_pkg::*;
#(
	parameter int unsigned FRAME_SIZE = FRAME_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample_a [15:0], sample_b [31:16], sample_position [42:32]
	input  logic [47:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// windowed_sample [16:0]
	output logic [23:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [16:0] FS_LAST = 17'(FRAME_SIZE - 1);

	comb_mode_t mode_q;
	win_kind_t  kind_q;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	logic signed [SAMPLE_W-1:0] sa;
	logic signed [SAMPLE_W-1:0] sb;
	logic [POS_W-1:0]           pos;
	logic signed [31:0]         rnd;
	logic signed [33:0]         res;

	logic [2:0][PH_W-1:0] ph;
	cos_val_t [2:0]       cv;
	logic [WEIGHT_W-1:0]  weight;

	logic signed [31:0]       prod_s1;
	logic signed [COMB_W-1:0] sum_s1;
	comb_mode_t               mode_s1;
	logic signed [COMB_W-1:0] comb_s [2:24];
	logic                     fend_s [1:26];
	logic signed [33:0]       fprod_s25;
	logic [OUT_W-1:0]         out_s26;

	// Register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= COMB_MUL;
			kind_q <= WIN_NONE;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_COMBINE: mode_q <= comb_mode_t'(pwdata[0]);
				REG_WINDOW:  kind_q <= win_kind_t'(pwdata[1:0]);
				default:     mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_COMBINE: prdata = {31'd0, mode_q};
			REG_WINDOW:  prdata = {30'd0, kind_q};
			default:     prdata = '0;
		endcase
	end

	// Stage enables: a stage loads when m_tready is high or any stage from it to the output is empty
	always_comb begin
		for (int i = 0; i < NUM_STAGES; i++) begin
			en[i] = m_tready | (|(~vld_q & ({NUM_STAGES{1'b1}} << i)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	// Input item
	assign sa  = signed'(s_tdata[15:0]);
	assign sb  = signed'(s_tdata[31:16]);
	assign pos = s_tdata[42:32];

	// Combine: product or sum of the two samples
	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= 32'(sa) * 32'(sb);
			sum_s1  <= COMB_W'(sa) + COMB_W'(sb);
			mode_s1 <= mode_q;
		end
	end

	assign rnd = prod_s1 + 32'sd16384;

	// Combined sample and frame marker wait for the weight
	always_ff @(posedge clk) begin
		if (en[0]) begin
			fend_s[1] <= ({6'd0, pos} == FS_LAST);
		end
		if (en[1]) begin
			comb_s[2] <= (mode_s1 == COMB_ADD) ? sum_s1 : rnd[31:15];
		end
		for (int k = 3; k <= 24; k++) begin
			if (en[k-1]) begin
				comb_s[k] <= comb_s[k-1];
			end
		end
		for (int k = 2; k <= 26; k++) begin
			if (en[k-1]) begin
				fend_s[k] <= fend_s[k-1];
			end
		end
	end

	// Weight path
	ttmw_phase #(
		.FRAME_SIZE(FRAME_SIZE)
	) u_phase (
		.clk(clk),
		.en (en[PH_N-1:0]),
		.pos(pos),
		.ph (ph)
	);

	for (genvar h = 0; h < 3; h++) begin : g_lane
		ttmw_cos u_cos (
			.clk (clk),
			.en  (en[COS_BASE +: COS_N]),
			.ph  (ph[h]),
			.cval(cv[h])
		);
	end

	ttmw_wsum u_wsum (
		.clk   (clk),
		.en    (en[WS_BASE +: WS_N]),
		.kind  (kind_q),
		.cv    (cv),
		.weight(weight)
	);

	// Apply the weight and round half up to Q2.15
	always_ff @(posedge clk) begin
		if (en[OUT_BASE]) begin
			fprod_s25 <= 34'(comb_s[24]) * 34'(signed'({1'b0, weight}));
		end
	end

	assign res = fprod_s25 + 34'sd16384;

	always_ff @(posedge clk) begin
		if (en[OUT_BASE+1]) begin
			out_s26 <= res[31:15];
		end
	end

	assign m_tvalid = vld_q[NUM_STAGES-1];
	assign m_tdata  = {7'd0, out_s26};
	assign m_tlast  = fend_s[26];

endmodule
